[src/vsr_pkg.sv]
// Shared types and constants of the voice superframe repair unit.
`timescale 1ns / 1ps

package vsr_pkg;

	// Default superframe length in frames.
	localparam int FRAMES_DEFAULT = 21;

	// Width of the sequence counter.
	localparam int SEQ_W = 7;

	// Depth of the command queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Frame kinds on the input side.
	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_VOICE  = 2'd1,
		OP_END    = 2'd2,
		OP_LOST   = 2'd3
	} op_t;

	// Voice patterns and control codes.
	localparam logic [31:0] PAT_HIGH    = 32'h9E8D3288;
	localparam logic [63:0] SYNC_LOW    = 64'h261A3F61E8552D16;
	localparam logic [63:0] SILENCE_LOW = 64'h261A3F61E8704F93;
	localparam logic [23:0] SYNC_TEXT   = 24'h552D16;
	localparam logic [7:0]  CTRL_HEADER = 8'h80;
	localparam logic [SEQ_W-1:0] SEQ_END_MARK = 7'h40;

	// Register map.
	localparam logic REG_MODULE_INDEX = 1'b0;

	// Module index codes.
	localparam logic [1:0] MOD_B = 2'd1;
	localparam logic [1:0] MOD_C = 2'd2;
	localparam logic [1:0] CODE_OTHER = 2'd3;

	// One command from the front part: an optional sync frame, an optional run of
	// silence frames, then the final frame of the item.
	typedef struct packed {
		logic             is_header;
		logic [15:0]      tag;
		logic             pre_sync;
		logic             do_fill;
		logic [SEQ_W-1:0] fill_seq;
		logic [7:0]       final_ctrl;
		logic [31:0]      final_high;
		logic [63:0]      final_low;
	} cmd_t;

endpackage

[src/vsr_front.sv]
// Front part: accepts items, tracks the stream state and classifies each item.
`timescale 1ns / 1ps

module vsr_front #(
	parameter int FRAMES_PER_SUPERFRAME = vsr_pkg::FRAMES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            opcode,
	input  logic [23:0]           sync_text,
	input  logic [31:0]           voice_high,
	input  logic [63:0]           voice_low,
	input  logic [15:0]           new_stream_id,
	output logic                  cmd_push,
	output vsr_pkg::cmd_t         cmd
);

	localparam logic [vsr_pkg::SEQ_W-1:0] FRAMES =
		vsr_pkg::SEQ_W'(FRAMES_PER_SUPERFRAME);

	logic                        active_q;
	logic                        awaiting_q;
	logic [vsr_pkg::SEQ_W-1:0]   seq_q;
	logic [15:0]                 tag_q;

	logic                        active_d;
	logic                        awaiting_d;
	logic [vsr_pkg::SEQ_W-1:0]   seq_d;
	logic [15:0]                 tag_d;
	logic                        emits;
	logic                        is_sync;
	logic [vsr_pkg::SEQ_W-1:0]   voice_seq;
	logic [vsr_pkg::SEQ_W-1:0]   close_seq;

	// Work out the whole effect of one item on the stream state in closed form.
	always_comb begin
		active_d   = active_q;
		awaiting_d = awaiting_q;
		seq_d      = seq_q;
		tag_d      = tag_q;
		emits      = 1'b0;
		is_sync    = (sync_text == vsr_pkg::SYNC_TEXT);
		voice_seq  = seq_q;
		close_seq  = seq_q | vsr_pkg::SEQ_END_MARK;

		cmd            = '0;
		cmd.tag        = tag_q;
		cmd.fill_seq   = seq_q;

		case (vsr_pkg::op_t'(opcode))
			vsr_pkg::OP_HEADER: begin
				emits          = 1'b1;
				cmd.is_header  = 1'b1;
				cmd.tag        = new_stream_id;
				cmd.final_ctrl = vsr_pkg::CTRL_HEADER;
				active_d       = 1'b1;
				awaiting_d     = 1'b1;
				seq_d          = FRAMES;
				tag_d          = new_stream_id;
			end
			vsr_pkg::OP_VOICE: begin
				emits = active_q;
				if (is_sync) begin
					// A sync frame closes out the superframe with silence.
					cmd.do_fill = (seq_q < FRAMES);
					voice_seq   = '0;
				end else if (awaiting_q || seq_q >= FRAMES) begin
					// Missing sync: insert one and start at sequence one.
					cmd.pre_sync = 1'b1;
					voice_seq    = vsr_pkg::SEQ_W'(1);
				end
				cmd.final_ctrl = {1'b0, voice_seq};
				cmd.final_high = voice_high;
				cmd.final_low  = voice_low;
				if (active_q) begin
					awaiting_d = 1'b0;
					seq_d      = voice_seq + vsr_pkg::SEQ_W'(1);
				end
			end
			default: begin
				// End of transmission or lost frame: one closing frame.
				emits          = active_q;
				cmd.final_ctrl = {1'b0, close_seq};
				cmd.final_high = vsr_pkg::PAT_HIGH;
				cmd.final_low  = (seq_q == '0) ? vsr_pkg::SYNC_LOW : vsr_pkg::SILENCE_LOW;
				if (active_q) begin
					seq_d    = close_seq + vsr_pkg::SEQ_W'(1);
					active_d = 1'b0;
				end
			end
		endcase
	end

	assign cmd_push = accept && emits;

	// Stream state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			awaiting_q <= 1'b0;
			seq_q      <= FRAMES;
			tag_q      <= '0;
		end else if (accept) begin
			active_q   <= active_d;
			awaiting_q <= awaiting_d;
			seq_q      <= seq_d;
			tag_q      <= tag_d;
		end
	end

endmodule

[src/vsr_cmd_queue.sv]
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module vsr_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vsr_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output vsr_pkg::cmd_t head
);

	localparam int PTR_W = (vsr_pkg::QUEUE_DEPTH > 1) ? $clog2(vsr_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(vsr_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(vsr_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(vsr_pkg::QUEUE_DEPTH);

	vsr_pkg::cmd_t      entry_q [vsr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/vsr_back.sv]
// Back part: expands each command into result items, one per cycle while the results are popped.
`timescale 1ns / 1ps

module vsr_back #(
	parameter int FRAMES_PER_SUPERFRAME = vsr_pkg::FRAMES_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  vsr_pkg::cmd_t head,
	output logic          head_pop,
	input  logic [1:0]    module_code_in,
	input  logic          pop,
	output logic          empty,
	output logic          is_header,
	output logic [15:0]   stream_tag,
	output logic [1:0]    module_code,
	output logic [7:0]    ctrl_code,
	output logic [31:0]   payload_high,
	output logic [63:0]   payload_low,
	output logic          last_of_run
);

	localparam logic [vsr_pkg::SEQ_W-1:0] FRAMES =
		vsr_pkg::SEQ_W'(FRAMES_PER_SUPERFRAME);

	typedef enum logic [1:0] {
		PH_START,
		PH_SYNC,
		PH_FILL,
		PH_FINAL
	} phase_t;

	phase_t                     phase_q;
	phase_t                     cur_phase;
	phase_t                     next_phase;
	logic [vsr_pkg::SEQ_W-1:0]  seq_q;
	logic [vsr_pkg::SEQ_W-1:0]  cur_seq;
	logic [vsr_pkg::SEQ_W-1:0]  seq_inc;
	logic                       out_valid_q;
	logic                       step;

	assign empty = !out_valid_q;
	assign step  = head_valid && (!out_valid_q || pop);

	// Pick the current phase; a fresh command starts at its first part.
	always_comb begin
		if (phase_q == PH_START) begin
			cur_seq = head.fill_seq;
			if (head.pre_sync) begin
				cur_phase = PH_SYNC;
			end else if (head.do_fill) begin
				cur_phase = PH_FILL;
			end else begin
				cur_phase = PH_FINAL;
			end
		end else begin
			cur_seq   = seq_q;
			cur_phase = phase_q;
		end
		seq_inc = cur_seq + vsr_pkg::SEQ_W'(1);

		case (cur_phase)
			PH_SYNC:  next_phase = PH_FINAL;
			PH_FILL:  next_phase = (seq_inc < FRAMES) ? PH_FILL : PH_FINAL;
			default:  next_phase = PH_START;
		endcase
	end

	assign head_pop = step && (next_phase == PH_START);

	// Expansion state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			seq_q        <= '0;
			out_valid_q  <= 1'b0;
			is_header    <= 1'b0;
			stream_tag   <= '0;
			module_code  <= '0;
			ctrl_code    <= '0;
			payload_high <= '0;
			payload_low  <= '0;
			last_of_run  <= 1'b0;
		end else if (step) begin
			phase_q     <= next_phase;
			seq_q       <= seq_inc;
			out_valid_q <= 1'b1;
			stream_tag  <= head.tag;
			module_code <= module_code_in;
			case (cur_phase)
				PH_SYNC: begin
					is_header    <= 1'b0;
					ctrl_code    <= '0;
					payload_high <= vsr_pkg::PAT_HIGH;
					payload_low  <= vsr_pkg::SYNC_LOW;
					last_of_run  <= 1'b0;
				end
				PH_FILL: begin
					is_header    <= 1'b0;
					ctrl_code    <= {1'b0, cur_seq};
					payload_high <= vsr_pkg::PAT_HIGH;
					payload_low  <= vsr_pkg::SILENCE_LOW;
					last_of_run  <= 1'b0;
				end
				default: begin
					is_header    <= head.is_header;
					ctrl_code    <= head.final_ctrl;
					payload_high <= head.final_high;
					payload_low  <= head.final_low;
					last_of_run  <= 1'b1;
				end
			endcase
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[src/voice_superframe_repair_unit.sv]
// Top level of the voice superframe repair unit.
`timescale 1ns / 1ps

// Renumbers radio voice frames into superframes. Header, voice, end and lost
// frames enter through a queue-style push port; result items leave through a
// queue-style pop port. The front part classifies each item in the cycle it is
// accepted and queues one command, unless the frame lies outside a stream; the
// back part then delivers one result item per cycle while results are popped.
// An item gives one result for a header, end or lost frame, and up to
// FRAMES_PER_SUPERFRAME for a sync voice frame that pads a superframe with
// silence (twenty silence frames and the voice frame itself with the default
// of 21). Frames outside a stream are taken and give no result. The
// module_index register sits at byte address 0 of the configuration port.

module voice_superframe_repair_unit #(
	parameter int FRAMES_PER_SUPERFRAME = vsr_pkg::FRAMES_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input side.
	input  logic         push,
	output logic         full,
	input  logic [1:0]   opcode,
	input  logic [23:0]  sync_text,
	input  logic [31:0]  voice_high,
	input  logic [63:0]  voice_low,
	input  logic [15:0]  new_stream_id,
	// Result side.
	output logic         empty,
	input  logic         pop,
	output logic         is_header,
	output logic [15:0]  stream_tag,
	output logic [1:0]   module_code,
	output logic [7:0]   ctrl_code,
	output logic [31:0]  payload_high,
	output logic [63:0]  payload_low,
	output logic         last_of_run
);

	logic [1:0]     module_index_q;
	logic [1:0]     module_code_cur;
	logic           accept;
	logic           cmd_push;
	vsr_pkg::cmd_t  cmd;
	logic           head_valid;
	logic           head_pop;
	vsr_pkg::cmd_t  head;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_index_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == vsr_pkg::REG_MODULE_INDEX) begin
			module_index_q <= pwdata[1:0];
		end
	end
	assign prdata = (paddr[2] == vsr_pkg::REG_MODULE_INDEX) ? {30'b0, module_index_q} : '0;

	// Module code from the module index.
	always_comb begin
		case (module_index_q)
			vsr_pkg::MOD_B: module_code_cur = vsr_pkg::MOD_B;
			vsr_pkg::MOD_C: module_code_cur = vsr_pkg::MOD_C;
			default:        module_code_cur = vsr_pkg::CODE_OTHER;
		endcase
	end

	assign accept = push && !full;

	vsr_front #(
		.FRAMES_PER_SUPERFRAME(FRAMES_PER_SUPERFRAME)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.opcode       (opcode),
		.sync_text    (sync_text),
		.voice_high   (voice_high),
		.voice_low    (voice_low),
		.new_stream_id(new_stream_id),
		.cmd_push     (cmd_push),
		.cmd          (cmd)
	);

	vsr_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd),
		.full      (full),
		.pop       (head_pop),
		.head_valid(head_valid),
		.head      (head)
	);

	vsr_back #(
		.FRAMES_PER_SUPERFRAME(FRAMES_PER_SUPERFRAME)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.head_pop      (head_pop),
		.module_code_in(module_code_cur),
		.pop           (pop),
		.empty         (empty),
		.is_header     (is_header),
		.stream_tag    (stream_tag),
		.module_code   (module_code),
		.ctrl_code     (ctrl_code),
		.payload_high  (payload_high),
		.payload_low   (payload_low),
		.last_of_run   (last_of_run)
	);

endmodule
